>>> src/weighted_shortest_route_search_assert.svh
// Assertion macros for the shortest route search block.
`ifndef WEIGHTED_SHORTEST_ROUTE_SEARCH_ASSERT_SVH
`define WEIGHTED_SHORTEST_ROUTE_SEARCH_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define WSR_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define WSR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> src/wsr_pkg.sv
// Shared widths, codes and types of the shortest route search block.
package wsr_pkg;
   localparam int CityW         = 4;
   localparam int LenW          = 16;
   localparam int TotalW        = 20;
   localparam int StatusW       = 2;
   localparam int DistW         = 32;
   localparam int NodesDefault  = 16;
   localparam int DegreeDefault = 8;
   localparam logic [TotalW-1:0] TotalMax = '1;

   typedef enum logic {
      ACT_ADD   = 1'b0,
      ACT_ROUTE = 1'b1
   } action_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK      = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_NO_PATH = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_A,
      S_ADD_B,
      S_RESP,
      S_POP,
      S_SCAN_RD,
      S_SCAN_EV,
      S_TRACE,
      S_EMIT
   } state_type;
endpackage

>>> src/wsr_if.sv
// Request and response channel interfaces of the shortest route search block.
interface wsr_req_if
   import wsr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                action;
   logic [CityW-1:0]    city_a;
   logic [CityW-1:0]    city_b;
   logic [LenW-1:0]     edge_distance;

   modport source(output valid, action, city_a, city_b, edge_distance, input ready);
   modport sink(input valid, action, city_a, city_b, edge_distance, output ready);
endinterface

interface wsr_rsp_if
   import wsr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [StatusW-1:0]  status;
   logic [CityW-1:0]    path_city;
   logic [TotalW-1:0]   total_distance;
   logic                last;

   modport source(output valid, status, path_city, total_distance, last, input ready);
   modport sink(input valid, status, path_city, total_distance, last, output ready);
endinterface

>>> src/weighted_shortest_route_search.sv
// Shortest route search over a stored undirected weighted graph.
//
// req channel: one request is an add-edge (action 0) or a route query (action 1).
// rsp channel: an add gives one response (ok, unknown city or list full); a query
// gives one response per city of the route, start first, with last on the final
// one, or a single unknown-city / no-path response.
// An add's response is loaded after its two adjacency writes, and the next
// request can be taken as soon as that response is loaded. A query takes each
// city from the waiting ring and scans its adjacency entries through the one-port
// adjacency memory, a read state then an evaluate state per entry; once the ring
// is empty it back-traces the route city by city and emits one response per city.
// One request is worked at a time; req ready is high whenever no request is in
// progress, also while the final response still waits in the output register.
// A stalled receiver holds the response register, and the block waits on it only
// when it has a new response to load. Reset (synchronous, active high) empties the
// graph; no clearing pass is needed, since the adjacency memory is only read below each city's fill count.
`include "weighted_shortest_route_search_assert.svh"
module weighted_shortest_route_search
   import wsr_pkg::*;
#(
   parameter int NODES  = NodesDefault,
   parameter int DEGREE = DegreeDefault
) (
   input  logic       clock,
   input  logic       reset,
   wsr_req_if.sink    req,
   wsr_rsp_if.source  rsp
);
   localparam int NW  = $clog2(NODES);
   localparam int CW  = $clog2(NODES + 1);
   localparam int DCW = $clog2(DEGREE + 1);
   localparam int AW  = $clog2(NODES * DEGREE);
   localparam int SW  = NW + 1;

   // adjacency memory: {neighbor city, edge length}
   logic [NW+LenW-1:0] adj_mem [NODES*DEGREE];
   logic [NW+LenW-1:0] rd_ff;

   logic [DCW-1:0]   cnt_ff [NODES];
   logic [NODES-1:0] reached_ff;
   logic [NODES-1:0] waiting_ff;
   logic [DistW-1:0] best_ff [NODES];
   logic [NW-1:0]    came_ff [NODES];
   logic [NW-1:0]    ring_ff [NODES];
   logic [NW-1:0]    stack_ff [NODES];

   state_type        state_ff, state_in;
   logic [NW-1:0]    a_ff, a_in, b_ff, b_in;
   logic [LenW-1:0]  len_ff, len_in;
   status_type       resp_st_ff, resp_st_in;
   logic [NW-1:0]    head_ff, head_in;
   logic [CW-1:0]    qcnt_ff, qcnt_in;
   logic [NW-1:0]    cur_ff, cur_in;
   logic [DistW-1:0] cur_dist_ff, cur_dist_in;
   logic [DCW-1:0]   cur_cnt_ff, cur_cnt_in;
   logic [DCW-1:0]   k_ff, k_in;
   logic [TotalW-1:0] total_ff, total_in;
   logic [NW-1:0]    trace_ff, trace_in;
   logic [NW-1:0]    n_ff, n_in;
   logic [NW-1:0]    p_ff, p_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [CityW-1:0]  rsp_city_ff, rsp_city_in;
   logic [TotalW-1:0] rsp_total_ff, rsp_total_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_load;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [NW+LenW-1:0] mem_wdata;
   logic              cnt_inc;
   logic [NW-1:0]     cnt_idx;
   logic              init_q, pop, relax, enq, stack_we;
   logic [NW-1:0]     stack_idx, stack_data;
   logic [NW-1:0]     nb;
   logic [DistW-1:0]  nd;
   logic [NW-1:0]     tail;
   logic [SW-1:0]     tail_sum;
   logic              out_free;
   logic              a_ok, b_ok, add_full;

   function automatic logic [AW-1:0] slot(input logic [NW-1:0] c, input logic [DCW-1:0] k);
      return AW'(c) * AW'(DEGREE) + AW'(k);
   endfunction

   assign nb       = rd_ff[NW+LenW-1:LenW];
   assign nd       = cur_dist_ff + DistW'(rd_ff[LenW-1:0]);
   assign tail_sum = SW'(head_ff) + SW'(qcnt_ff);
   assign tail     = (tail_sum >= SW'(NODES)) ? NW'(tail_sum - SW'(NODES)) : NW'(tail_sum);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign a_ok     = 32'(req.city_a) < NODES;
   assign b_ok     = 32'(req.city_b) < NODES;

   always_comb begin
      if (NW'(req.city_a) == NW'(req.city_b)) begin
         add_full = 32'(cnt_ff[NW'(req.city_a)]) + 2 > DEGREE;
      end else begin
         add_full = 32'(cnt_ff[NW'(req.city_a)]) >= DEGREE ||
                    32'(cnt_ff[NW'(req.city_b)]) >= DEGREE;
      end
   end

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      len_in        = len_ff;
      resp_st_in    = resp_st_ff;
      head_in       = head_ff;
      qcnt_in       = qcnt_ff;
      cur_in        = cur_ff;
      cur_dist_in   = cur_dist_ff;
      cur_cnt_in    = cur_cnt_ff;
      k_in          = k_ff;
      total_in      = total_ff;
      trace_in      = trace_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_city_in   = '0;
      rsp_total_in  = '0;
      rsp_last_in   = 1'b1;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = slot(a_ff, cnt_ff[a_ff]);
      mem_wdata     = {b_ff, len_ff};
      mem_raddr     = slot(cur_ff, k_ff);
      cnt_inc       = 1'b0;
      cnt_idx       = a_ff;
      init_q        = 1'b0;
      pop           = 1'b0;
      relax         = 1'b0;
      enq           = 1'b0;
      stack_we      = 1'b0;
      stack_idx     = n_ff;
      stack_data    = trace_ff;
      req.ready     = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               a_in   = NW'(req.city_a);
               b_in   = NW'(req.city_b);
               len_in = req.edge_distance;
               if (!a_ok || !b_ok) begin
                  resp_st_in = ST_UNKNOWN;
                  state_in   = S_RESP;
               end else if (req.action == ACT_ADD) begin
                  if (add_full) begin
                     resp_st_in = ST_FULL;
                     state_in   = S_RESP;
                  end else begin
                     state_in = S_ADD_A;
                  end
               end else if (cnt_ff[NW'(req.city_a)] == '0 ||
                            cnt_ff[NW'(req.city_b)] == '0) begin
                  resp_st_in = ST_UNKNOWN;
                  state_in   = S_RESP;
               end else begin
                  init_q   = 1'b1;
                  head_in  = '0;
                  qcnt_in  = CW'(1);
                  state_in = S_POP;
               end
            end
         end
         S_ADD_A: begin
            mem_we   = 1'b1;
            cnt_inc  = 1'b1;
            state_in = S_ADD_B;
         end
         S_ADD_B: begin
            mem_we     = 1'b1;
            mem_waddr  = slot(b_ff, cnt_ff[b_ff]);
            mem_wdata  = {a_ff, len_ff};
            cnt_inc    = 1'b1;
            cnt_idx    = b_ff;
            resp_st_in = ST_OK;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_load      = 1'b1;
               rsp_status_in = resp_st_ff;
               state_in      = S_IDLE;
            end
         end
         S_POP: begin
            if (qcnt_ff == '0) begin
               if (!reached_ff[b_ff]) begin
                  resp_st_in = ST_NO_PATH;
                  state_in   = S_RESP;
               end else begin
                  total_in = (best_ff[b_ff] > DistW'(TotalMax)) ? TotalMax
                                                                 : TotalW'(best_ff[b_ff]);
                  trace_in = b_ff;
                  n_in     = '0;
                  state_in = S_TRACE;
               end
            end else begin
               pop         = 1'b1;
               cur_in      = ring_ff[head_ff];
               cur_dist_in = best_ff[ring_ff[head_ff]];
               cur_cnt_in  = cnt_ff[ring_ff[head_ff]];
               head_in     = (32'(head_ff) == NODES - 1) ? '0 : head_ff + 1'b1;
               qcnt_in     = qcnt_ff - 1'b1;
               k_in        = '0;
               state_in    = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (k_ff < cur_cnt_ff) begin
               mem_re   = 1'b1;
               state_in = S_SCAN_EV;
            end else begin
               state_in = S_POP;
            end
         end
         S_SCAN_EV: begin
            if (!reached_ff[nb] || nd < best_ff[nb]) begin
               relax = 1'b1;
               if (!waiting_ff[nb] && qcnt_ff < CW'(NODES)) begin
                  enq     = 1'b1;
                  qcnt_in = qcnt_ff + 1'b1;
               end
            end
            k_in     = k_ff + 1'b1;
            state_in = S_SCAN_RD;
         end
         S_TRACE: begin
            stack_we = 1'b1;
            if (trace_ff != a_ff && 32'(n_ff) < NODES - 1) begin
               n_in     = n_ff + 1'b1;
               trace_in = came_ff[trace_ff];
            end else begin
               stack_data = a_ff;
               p_in       = n_ff;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_load     = 1'b1;
               rsp_city_in  = CityW'(stack_ff[p_ff]);
               rsp_total_in = total_ff;
               rsp_last_in  = (p_ff == '0);
               if (p_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  p_in = p_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         qcnt_ff      <= '0;
         head_ff      <= '0;
         reached_ff   <= '0;
         waiting_ff   <= '0;
         for (int i = 0; i < NODES; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         qcnt_ff      <= qcnt_in;
         head_ff      <= head_in;
         if (cnt_inc) begin
            cnt_ff[cnt_idx] <= cnt_ff[cnt_idx] + 1'b1;
         end
         // new query: only the start city is reached and waiting
         if (init_q) begin
            reached_ff <= {{(NODES-1){1'b0}}, 1'b1} << a_in;
            waiting_ff <= {{(NODES-1){1'b0}}, 1'b1} << a_in;
         end
         if (pop) begin
            waiting_ff[ring_ff[head_ff]] <= 1'b0;
         end
         if (relax) begin
            reached_ff[nb] <= 1'b1;
         end
         if (enq) begin
            waiting_ff[nb] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      len_ff      <= len_in;
      resp_st_ff  <= resp_st_in;
      cur_ff      <= cur_in;
      cur_dist_ff <= cur_dist_in;
      cur_cnt_ff  <= cur_cnt_in;
      k_ff        <= k_in;
      total_ff    <= total_in;
      trace_ff    <= trace_in;
      n_ff        <= n_in;
      p_ff        <= p_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_city_ff   <= rsp_city_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_last_ff   <= rsp_last_in;
      end
      if (init_q) begin
         best_ff[a_in] <= '0;
         ring_ff[0]    <= a_in;
      end
      if (relax) begin
         best_ff[nb] <= nd;
         came_ff[nb] <= cur_ff;
      end
      if (enq) begin
         ring_ff[tail] <= nb;
      end
      if (stack_we) begin
         stack_ff[stack_idx] <= stack_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         adj_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= adj_mem[mem_raddr];
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.path_city      = rsp_city_ff;
   assign rsp.total_distance = rsp_total_ff;
   assign rsp.last           = rsp_last_ff;

   `WSR_ASSERT_NEXT(a_accept_busy, clock, reset, req.valid && req.ready,
      state_ff != S_IDLE, "request accepted but block stayed idle")
   `WSR_ASSERT_IMPL(a_scan_in_list, clock, reset, state_ff == S_SCAN_EV,
      k_ff < cur_cnt_ff, "adjacency scan past fill count")
   `WSR_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK,
      rsp_city_ff == '0 && rsp_total_ff == '0 && rsp_last_ff,
      "failure response carries route data")
endmodule
